>>> hw/rtl/crr_pkg.sv
package crr_pkg;

	localparam int WINDOW_CHUNKS = 8;
	localparam int IDX_W = (WINDOW_CHUNKS > 1) ? $clog2(WINDOW_CHUNKS) : 1;
	localparam int CNT_W = $clog2(WINDOW_CHUNKS + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;
	localparam logic [3:0] RETRY_RESET = 4'd5;
	localparam logic [12:0] CHUNK_RESET = 13'd256;
	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_DATA = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_SEND = 2'd0,
		KIND_FILL = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_WAITING = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_TIMEOUT = 2'd2,
		STAT_IGNORED = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_REQ = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_RETRY = 2'd1,
		CFG_CHUNK = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		func_t func;
		logic [7:0] target_id;
		logic [31:0] byte_offset;
		logic [15:0] data_length;
	} crr_in_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] out_id;
		logic [31:0] out_offset;
		logic [2:0] chunk_index;
		logic [12:0] copy_length;
		stat_t status;
		logic last;
	} crr_out_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [3:0] retry_limit;
		logic [12:0] chunk_bytes;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic [3:0] retries;
		logic [15:0] age;
	} slot_t;

	typedef struct packed {
		logic shift;
		slot_t d;
	} ring_ctl_t;

	function automatic logic [2:0] to_chunk_index(input logic [IDX_W-1:0] k);
		logic [31:0] w;
		w = 32'(k);
		return w[2:0];
	endfunction

	function automatic crr_out_t make_status(input stat_t st);
		crr_out_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

>>> hw/rtl/crr_cell.sv
module crr_cell (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input crr_pkg::slot_t d,
	output crr_pkg::slot_t q
);

	crr_pkg::slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

>>> hw/rtl/crr_seq.sv
module crr_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input crr_pkg::crr_in_t cmd,
	input crr_pkg::cfg_t cfg,
	input crr_pkg::slot_t head,
	output crr_pkg::ring_ctl_t ring,
	output logic busy,
	output logic result_valid,
	output crr_pkg::crr_out_t result
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN = 3'b010,
		S_FIN = 3'b100
	} state_t;

	localparam logic [crr_pkg::IDX_W-1:0] STEP_LAST =
		crr_pkg::IDX_W'(crr_pkg::WINDOW_CHUNKS - 1);
	localparam logic [crr_pkg::CNT_W-1:0] CNT_FULL =
		crr_pkg::CNT_W'(crr_pkg::WINDOW_CHUNKS);

	state_t state_q;
	logic [crr_pkg::IDX_W-1:0] step_q;
	crr_pkg::func_t op_q;
	logic [7:0] id_q;
	logic [31:0] base_q;
	logic [31:0] off_q;
	logic [31:0] rsp_off_q;
	logic [15:0] dlen_q;
	logic active_q;
	logic hit_q;
	logic quiet_q;
	logic [crr_pkg::CNT_W-1:0] cnt_q;
	logic res_valid_q;
	crr_pkg::crr_out_t res_q;

	crr_pkg::slot_t head_next;
	crr_pkg::crr_out_t slot_res;
	logic slot_emit;
	logic slot_fail;
	logic slot_hit;
	logic [15:0] age_inc;
	logic [12:0] clamp_len;

	always_comb begin
		clamp_len = (dlen_q < {3'b000, cfg.chunk_bytes}) ? dlen_q[12:0] : cfg.chunk_bytes;
		age_inc = (head.age == crr_pkg::AGE_MAX) ? head.age : head.age + 16'd1;
		head_next = head;
		slot_emit = 1'b0;
		slot_fail = 1'b0;
		slot_hit = 1'b0;
		slot_res = '0;
		slot_res.kind = crr_pkg::KIND_SEND;
		slot_res.out_id = id_q;
		slot_res.out_offset = off_q;
		slot_res.chunk_index = crr_pkg::to_chunk_index(step_q);
		slot_res.status = crr_pkg::STAT_WAITING;
		if (!quiet_q) begin
			case (op_q)
				crr_pkg::FUNC_START: begin
					head_next.phase = crr_pkg::PH_REQ;
					head_next.retries = 4'd0;
					head_next.age = 16'd0;
					slot_emit = 1'b1;
				end
				crr_pkg::FUNC_TICK: begin
					if (head.phase == crr_pkg::PH_REQ) begin
						head_next.age = age_inc;
						if (age_inc > cfg.timeout_ticks) begin
							if (head.retries >= cfg.retry_limit) begin
								slot_fail = 1'b1;
							end else begin
								head_next.age = 16'd0;
								head_next.retries = head.retries + 4'd1;
								slot_emit = 1'b1;
							end
						end
					end
				end
				crr_pkg::FUNC_DATA: begin
					if (!hit_q && head.phase == crr_pkg::PH_REQ && off_q == rsp_off_q) begin
						head_next.phase = crr_pkg::PH_DONE;
						slot_emit = 1'b1;
						slot_hit = 1'b1;
						slot_res.kind = crr_pkg::KIND_FILL;
						slot_res.copy_length = clamp_len;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ring.shift = (state_q == S_RUN);
	assign ring.d = head_next;
	assign busy = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			op_q <= crr_pkg::FUNC_NONE;
			id_q <= '0;
			base_q <= '0;
			active_q <= 1'b0;
			hit_q <= 1'b0;
			quiet_q <= 1'b0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= cmd.func;
						step_q <= '0;
						hit_q <= 1'b0;
						quiet_q <= 1'b0;
						cnt_q <= '0;
						case (cmd.func)
							crr_pkg::FUNC_START: begin
								active_q <= 1'b1;
								id_q <= cmd.target_id;
								base_q <= cmd.byte_offset;
								state_q <= S_RUN;
							end
							crr_pkg::FUNC_TICK: begin
								if (active_q) begin
									state_q <= S_RUN;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							crr_pkg::FUNC_DATA: begin
								if (active_q && cmd.target_id == id_q) begin
									state_q <= S_RUN;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_RUN: begin
					step_q <= step_q + 1'b1;
					hit_q <= hit_q | slot_hit;
					if (head_next.phase == crr_pkg::PH_DONE) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (slot_fail) begin
						// remaining slots only rotate back into place
						quiet_q <= 1'b1;
						active_q <= 1'b0;
						res_valid_q <= 1'b1;
					end else if (slot_emit) begin
						res_valid_q <= 1'b1;
					end
					if (step_q == STEP_LAST) begin
						state_q <= (quiet_q || slot_fail) ? S_IDLE : S_FIN;
					end
				end
				S_FIN: begin
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
					if (op_q == crr_pkg::FUNC_DATA && hit_q && cnt_q == CNT_FULL) begin
						active_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side: running offset, response capture and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rsp_off_q <= cmd.byte_offset;
				dlen_q <= cmd.data_length;
				off_q <= (cmd.func == crr_pkg::FUNC_START) ? cmd.byte_offset : base_q;
				res_q <= crr_pkg::make_status(crr_pkg::STAT_IGNORED);
			end
			S_RUN: begin
				off_q <= off_q + {19'd0, cfg.chunk_bytes};
				if (slot_fail) begin
					res_q <= crr_pkg::make_status(crr_pkg::STAT_TIMEOUT);
				end else begin
					res_q <= slot_res;
				end
			end
			S_FIN: begin
				if (op_q == crr_pkg::FUNC_DATA && !hit_q) begin
					res_q <= crr_pkg::make_status(crr_pkg::STAT_IGNORED);
				end else if (op_q == crr_pkg::FUNC_DATA && cnt_q == CNT_FULL) begin
					res_q <= crr_pkg::make_status(crr_pkg::STAT_COMPLETE);
				end else begin
					res_q <= crr_pkg::make_status(crr_pkg::STAT_WAITING);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.kind == crr_pkg::KIND_STATUS) == result.last))
		else $error("status result and last flag disagree");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && step_q == STEP_LAST) |=> (state_q != S_RUN))
		else $error("slot pass longer than the window");

	a_fail_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == crr_pkg::KIND_STATUS &&
		 result.status == crr_pkg::STAT_TIMEOUT) |-> !active_q)
		else $error("window still open after timeout failure");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("completed chunk count beyond window size");

	a_quiet_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && quiet_q) |=> !result_valid)
		else $error("transfer after timeout failure");
`endif

endmodule

>>> hw/rtl/chunk_request_retry_window_unit.sv
// Keeps a window of eight chunk requests for one target and re-requests chunks that time
// out. A command is taken on a clock edge with start high and busy low. A start command
// gives eight send transfers and a waiting status on back-to-back cycles, the first once
// the slot pass has begun and the result register has taken it. A tick or data response
// on an open window with matching id is busy while the slot ring makes a full turn, then
// gives the closing status; a tick sends each slot it re-requests and a response fills
// the one requested slot whose offset it matches. After a timeout failure the status
// shows on the cycle after the failing slot is visited and the ring finishes its turn
// silently, so busy falls at the end of the turn with no closing step. A tick or response
// on a closed window, a response with a foreign id or an unknown function gives its
// status on the next cycle without raising busy. Every result shows for one cycle with
// result_valid and cannot be held off; the final one of a command has last set.
// Configuration writes belong in idle time.
module chunk_request_retry_window_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input crr_pkg::crr_in_t cmd,
	output logic result_valid,
	output crr_pkg::crr_out_t result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	crr_pkg::cfg_t cfg_q;
	crr_pkg::ring_ctl_t ring;
	crr_pkg::slot_t slot_q [crr_pkg::WINDOW_CHUNKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= crr_pkg::TIMEOUT_RESET;
			cfg_q.retry_limit <= crr_pkg::RETRY_RESET;
			cfg_q.chunk_bytes <= crr_pkg::CHUNK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				crr_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				crr_pkg::CFG_RETRY: cfg_q.retry_limit <= cfg_data[3:0];
				crr_pkg::CFG_CHUNK: cfg_q.chunk_bytes <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// slot ring: the head cell is worked on, the updated slot re-enters at the tail
	for (genvar i = 0; i < crr_pkg::WINDOW_CHUNKS; i++) begin : g_ring
		if (i == crr_pkg::WINDOW_CHUNKS - 1) begin : g_tail
			crr_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ring.shift),
				.d(ring.d),
				.q(slot_q[i])
			);
		end else begin : g_body
			crr_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ring.shift),
				.d(slot_q[i+1]),
				.q(slot_q[i])
			);
		end
	end

	crr_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.cfg(cfg_q),
		.head(slot_q[0]),
		.ring(ring),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

endmodule
